FILE: sv/pbs_pkg.sv
// ----------------------------------------------------------------------------
// pbs_pkg: shared types, constants and helpers of the pre-token splitter
// Character classes, token kinds, saturating length counters and the result
// record that travels from the scanner to the output buffer.
// ----------------------------------------------------------------------------
package pbs_pkg;

  localparam int LENGTH_BITS = 16;
  localparam int CNT_W       = LENGTH_BITS + 1;
  localparam int LEN_W       = 16;
  localparam int MAX_RES     = 4;
  localparam int RES_CNT_W   = $clog2(MAX_RES + 1);
  localparam int RES_IDX_W   = $clog2(MAX_RES);

  // counters keep one overflow value above the maximum
  localparam logic [CNT_W-1:0] CNT_CAP = {1'b1, {LENGTH_BITS{1'b0}}};
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_CAP - CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);

  localparam logic [2:0] KIND_LETTER = 3'd0;
  localparam logic [2:0] KIND_DIGIT  = 3'd1;
  localparam logic [2:0] KIND_PUNCT  = 3'd2;
  localparam logic [2:0] KIND_WS_NL  = 3'd3;
  localparam logic [2:0] KIND_WS     = 3'd4;

  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [2:0]       kind;
    logic             sat;
    logic             last;
  } res_t;

  typedef struct packed {
    res_t [MAX_RES-1:0]   e;
    logic [RES_CNT_W-1:0] n;
  } rlist_t;

  function automatic logic is_up(logic [7:0] b);
    return (b >= CH_UP_A) && (b <= CH_UP_Z);
  endfunction

  function automatic logic is_lo(logic [7:0] b);
    return (b >= CH_LO_A) && (b <= CH_LO_Z);
  endfunction

  function automatic logic is_let(logic [7:0] b);
    return is_up(b) || is_lo(b);
  endfunction

  function automatic logic is_dig(logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic is_nl(logic [7:0] b);
    return (b == CH_CR) || (b == CH_LF);
  endfunction

  function automatic logic is_sp(logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR) ||
           (b == CH_FF) || (b == CH_VT);
  endfunction

  function automatic logic is_pun(logic [7:0] b);
    return !is_sp(b) && !is_let(b) && !is_dig(b);
  endfunction

  function automatic logic [CNT_W-1:0] add_cap(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, CNT_CAP}) ? CNT_CAP : s[CNT_W-1:0];
  endfunction

  // append one token to the list, dropping it once the list is full
  function automatic rlist_t push_res(rlist_t l, logic [CNT_W-1:0] len, logic [2:0] kind);
    rlist_t r;
    res_t   e;
    r      = l;
    e.sat  = (len >= CNT_CAP);
    e.len  = e.sat ? LEN_W'(CNT_MAX) : LEN_W'(len);
    e.kind = kind;
    e.last = 1'b0;
    if (l.n < RES_CNT_W'(MAX_RES)) begin
      r.e[l.n[RES_IDX_W-1:0]] = e;
      r.n = l.n + RES_CNT_W'(1);
    end
    return r;
  endfunction

endpackage

FILE: sv/pbs_scan.sv
// ----------------------------------------------------------------------------
// pbs_scan: token boundary scanner
// Holds the scan mode and length counters and, for each accepted byte, works
// out in one pass the list of tokens that the byte finishes.
// ----------------------------------------------------------------------------
module pbs_scan
  import pbs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic       eot_i,
  output rlist_t     list_o
);

  localparam logic [2:0] M_IDLE  = 3'd0;
  localparam logic [2:0] M_LEADP = 3'd1;
  localparam logic [2:0] M_PUNCT = 3'd2;
  localparam logic [2:0] M_PTAIL = 3'd3;
  localparam logic [2:0] M_UPPER = 3'd4;
  localparam logic [2:0] M_LOWER = 3'd5;
  localparam logic [2:0] M_WS    = 3'd6;

  logic [2:0]       mode_q, mode_d;
  logic             lead_sp_q, lead_sp_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             saw_nl_q, saw_nl_d;
  logic [CNT_W-1:0] tnc_q, tnc_d;
  logic [CNT_W-1:0] anc_q, anc_d;

  always_comb begin
    rlist_t           l;
    logic             start;
    logic [CNT_W-1:0] m;

    l         = '0;
    start     = 1'b0;
    m         = anc_q;
    mode_d    = mode_q;
    lead_sp_d = lead_sp_q;
    cnt_d     = cnt_q;
    saw_nl_d  = saw_nl_q;
    tnc_d     = tnc_q;
    anc_d     = anc_q;

    unique case (mode_q)
      M_LEADP: begin
        if (is_let(byte_i)) begin
          mode_d = is_up(byte_i) ? M_UPPER : M_LOWER;
          cnt_d  = add_cap(cnt_q, CNT_ONE);
        end else if (is_pun(byte_i)) begin
          mode_d = M_PUNCT;
          cnt_d  = add_cap(cnt_q, CNT_ONE);
        end else if (is_nl(byte_i)) begin
          mode_d = M_PTAIL;
          cnt_d  = add_cap(cnt_q, CNT_ONE);
        end else begin
          l     = push_res(l, cnt_q, KIND_PUNCT);
          start = 1'b1;
        end
      end
      M_PUNCT: begin
        if (is_pun(byte_i)) begin
          cnt_d = add_cap(cnt_q, CNT_ONE);
        end else if (is_nl(byte_i)) begin
          mode_d = M_PTAIL;
          cnt_d  = add_cap(cnt_q, CNT_ONE);
        end else begin
          l     = push_res(l, cnt_q, KIND_PUNCT);
          start = 1'b1;
        end
      end
      M_PTAIL: begin
        if (is_nl(byte_i) || (byte_i == CH_SLASH)) begin
          cnt_d = add_cap(cnt_q, CNT_ONE);
        end else begin
          l     = push_res(l, cnt_q, KIND_PUNCT);
          start = 1'b1;
        end
      end
      M_UPPER: begin
        if (is_let(byte_i)) begin
          if (is_lo(byte_i)) mode_d = M_LOWER;
          cnt_d = add_cap(cnt_q, CNT_ONE);
        end else begin
          l     = push_res(l, cnt_q, KIND_LETTER);
          start = 1'b1;
        end
      end
      M_LOWER: begin
        if (is_lo(byte_i)) begin
          cnt_d = add_cap(cnt_q, CNT_ONE);
        end else begin
          l     = push_res(l, cnt_q, KIND_LETTER);
          start = 1'b1;
        end
      end
      M_WS: begin
        if (is_sp(byte_i)) begin
          if (is_nl(byte_i)) begin
            tnc_d    = add_cap(tnc_q, add_cap(anc_q, CNT_ONE));
            anc_d    = '0;
            saw_nl_d = 1'b1;
          end else begin
            anc_d = add_cap(anc_q, CNT_ONE);
          end
          lead_sp_d = (byte_i == CH_SPACE);
        end else begin
          // close the run: newline part, then all but the last byte
          if (saw_nl_q) l = push_res(l, tnc_q, KIND_WS_NL);
          saw_nl_d  = 1'b0;
          tnc_d     = '0;
          anc_d     = '0;
          lead_sp_d = 1'b0;
          if (m >= CNT_TWO) begin
            l = push_res(l, (m >= CNT_CAP) ? CNT_CAP : m - CNT_ONE, KIND_WS);
            m = CNT_ONE;
          end
          if (m == CNT_ONE) begin
            if (is_let(byte_i)) begin
              mode_d = is_up(byte_i) ? M_UPPER : M_LOWER;
              cnt_d  = CNT_TWO;
            end else if (is_pun(byte_i) && lead_sp_q) begin
              mode_d = M_PUNCT;
              cnt_d  = CNT_TWO;
            end else begin
              // lone lead byte goes out by itself
              l     = push_res(l, CNT_ONE, KIND_WS);
              start = 1'b1;
            end
          end else begin
            start = 1'b1;
          end
        end
      end
      default: start = 1'b1;
    endcase

    if (start) begin
      cnt_d = CNT_ONE;
      if (is_up(byte_i)) begin
        mode_d = M_UPPER;
      end else if (is_lo(byte_i)) begin
        mode_d = M_LOWER;
      end else if (is_dig(byte_i)) begin
        l      = push_res(l, CNT_ONE, KIND_DIGIT);
        mode_d = M_IDLE;
        cnt_d  = '0;
      end else if (is_sp(byte_i)) begin
        mode_d    = M_WS;
        cnt_d     = '0;
        saw_nl_d  = is_nl(byte_i);
        tnc_d     = is_nl(byte_i) ? CNT_ONE : '0;
        anc_d     = is_nl(byte_i) ? '0 : CNT_ONE;
        lead_sp_d = (byte_i == CH_SPACE);
      end else begin
        mode_d = M_LEADP;
      end
    end

    if (eot_i) begin
      // flush whatever is open, then drop back to idle
      unique case (mode_d)
        M_LEADP, M_PUNCT, M_PTAIL: l = push_res(l, cnt_d, KIND_PUNCT);
        M_UPPER, M_LOWER:          l = push_res(l, cnt_d, KIND_LETTER);
        M_WS: begin
          if (saw_nl_d) l = push_res(l, tnc_d, KIND_WS_NL);
          if (anc_d != '0) l = push_res(l, anc_d, KIND_WS);
        end
        default: ;
      endcase
      mode_d    = M_IDLE;
      cnt_d     = '0;
      saw_nl_d  = 1'b0;
      tnc_d     = '0;
      anc_d     = '0;
      lead_sp_d = 1'b0;
    end

    if (l.n != '0) l.e[RES_IDX_W'(l.n - RES_CNT_W'(1))].last = 1'b1;
    list_o = l;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= M_IDLE;
      lead_sp_q <= 1'b0;
      cnt_q     <= '0;
      saw_nl_q  <= 1'b0;
      tnc_q     <= '0;
      anc_q     <= '0;
    end else if (step_i) begin
      mode_q    <= mode_d;
      lead_sp_q <= lead_sp_d;
      cnt_q     <= cnt_d;
      saw_nl_q  <= saw_nl_d;
      tnc_q     <= tnc_d;
      anc_q     <= anc_d;
    end
  end

endmodule

FILE: sv/pretoken_boundary_splitter.sv
// ----------------------------------------------------------------------------
// pretoken_boundary_splitter: ASCII pre-token boundary splitter
// Streams text bytes in and token length/kind records out.
// ----------------------------------------------------------------------------
// Latency: the first token of a byte is shown in the cycle after the byte is taken.
// Throughput: one byte per cycle while each byte finishes at most one token
//   and the output is ready; a byte that finishes k tokens (k up to 4) holds the
//   input while the single output port drains the buffer, one per ready cycle.
// Reset: asynchronous, active low; clears the scan state and empties the buffer.
module pretoken_boundary_splitter
  import pbs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tlast,   // end_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] token_length
  output logic [3:0]  m_axis_tuser,   // [2:0] token_kind, [3] length_saturated
  output logic        m_axis_tlast    // last_of_run
);

  rlist_t                  list;
  res_t [MAX_RES-1:0]      buf_q, buf_d;
  logic [RES_CNT_W-1:0]    fill_q, fill_d;
  logic                    take, pop;

  assign pop           = m_axis_tvalid && m_axis_tready;
  // take the next byte while the buffer is empty or empties in this cycle
  assign s_axis_tready = (fill_q == '0) || ((fill_q == RES_CNT_W'(1)) && m_axis_tready);
  assign take          = s_axis_tvalid && s_axis_tready;

  pbs_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (take),
    .byte_i (s_axis_tdata),
    .eot_i  (s_axis_tlast),
    .list_o (list)
  );

  always_comb begin
    buf_d  = buf_q;
    fill_d = fill_q;
    if (take) begin
      buf_d  = list.e;
      fill_d = list.n;
    end else if (pop) begin
      // advance: next token moves to the head
      for (int i = 0; i < MAX_RES - 1; i++) buf_d[i] = buf_q[i+1];
      fill_d = fill_q - RES_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  assign m_axis_tvalid = (fill_q != '0);
  assign m_axis_tdata  = buf_q[0].len;
  assign m_axis_tuser  = {buf_q[0].sat, buf_q[0].kind};
  assign m_axis_tlast  = buf_q[0].last;

endmodule

FILE: sv/pbs_checker.sv
// ----------------------------------------------------------------------------
// pbs_checker: port-level checks for the pre-token splitter
// Watches both stream groups and flags ordering and hand-off slips.
// ----------------------------------------------------------------------------
module pbs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [3:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // a new request is taken only while the pending results drain
  a_take_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid || m_axis_tready)
    else $error("input taken with results left behind");

  // the end of text always releases at least one token
  a_eot_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> m_axis_tvalid)
    else $error("end of text released nothing");

  // tokens of one run follow without a gap
  a_run_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("run cut before its last token");

  // no empty token
  a_len_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata != 16'd0)
    else $error("zero-length token");

endmodule

bind pretoken_boundary_splitter pbs_checker u_pbs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
